// ===== hw/rtl/bts_pkg.sv =====
// Shared types and constants of the byte translate / delete / squeeze core.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package bts_pkg;

   // Field widths.
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // Command codes of the request channel.
   localparam logic CMD_DATA        = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   // Control register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DELETE_ENABLE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_ENABLE = 8'd1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef logic [BYTE_W-1:0] byte_type;

   // Mode bits held in the control registers.
   typedef struct packed {
      logic delete_enable;
      logic squeeze_enable;
   } cfg_type;

   // One surviving byte on its way to the back.
   typedef struct packed {
      byte_type mapped;
      logic     squeeze_mark;
   } queue_entry_type;

   // Fill state of the queue.
   typedef struct packed {
      logic                   not_empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bts_if.sv =====
// Channel interfaces of the byte translate / delete / squeeze core.
// Depends on bts_pkg for field widths.
`default_nettype none

// Request channel: data bytes and table writes.
interface bts_req_if;
   import bts_pkg::*;

   logic     valid;
   logic     ready;
   logic     cmd;
   byte_type byte_value;
   byte_type map_to;
   logic     mark_delete;
   logic     mark_squeeze;

   modport source (output valid, cmd, byte_value, map_to, mark_delete, mark_squeeze,
                   input ready);
   modport sink   (input valid, cmd, byte_value, map_to, mark_delete, mark_squeeze,
                   output ready);
endinterface

// Response channel: emitted bytes.
interface bts_rsp_if;
   import bts_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;

   modport source (output valid, out_byte, input ready);
   modport sink   (input valid, out_byte, output ready);
endinterface

// Control register write channel.
interface bts_csr_if;
   import bts_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bts_front.sv =====
// Front of the core: accepts requests, owns the translation table and both
// set memories, looks bytes up and drops deleted ones. Depends on bts_pkg, bts_if.
`default_nettype none

module bts_front #(
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bts_req_if.sink                        req_ch,
   input  wire bts_pkg::cfg_type          cfg,
   input  wire bts_pkg::queue_status_type queue_status,
   output logic                           push,
   output bts_pkg::queue_entry_type       push_entry
);
   import bts_pkg::*;

   localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam logic [BYTE_W:0] SYM_LIMIT = (BYTE_W + 1)'(SYMBOL_COUNT);

   typedef struct packed {
      byte_type map_to;
      logic     del_mark;
   } table_word_type;

   // Table memories; an entry never written since reset reads as identity and clear.
   table_word_type table_mem [SYMBOL_COUNT];
   logic           sq_mem    [SYMBOL_COUNT];

   logic [SYMBOL_COUNT-1:0] written_ff, written_in;

   // Lookup stage registers.
   logic           a_valid_ff;
   logic           a_hit_ff;
   byte_type       a_byte_ff;
   table_word_type a_word_ff;

   // Squeeze lookup stage registers.
   logic     b_valid_ff;
   byte_type b_mapped_ff;
   logic     b_del_ff;
   logic     b_sq_hit_ff;
   logic     b_sq_word_ff;

   logic             accept;
   logic             in_range;
   logic [IDX_W-1:0] idx;
   logic             table_wr;
   logic             data_rd;
   byte_type         a_mapped;
   logic             a_del;
   logic             a_sq_in_range;
   logic [IDX_W-1:0] a_sq_idx;
   logic [QUEUE_CNT_W-1:0] pending;

   // Room is reserved in the queue for every byte still in the lookup stages.
   assign pending = queue_status.count + QUEUE_CNT_W'(a_valid_ff) + QUEUE_CNT_W'(b_valid_ff);
   assign req_ch.ready = pending < QUEUE_CNT_W'(QUEUE_DEPTH);

   // Decode the accepted request.
   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = {1'b0, req_ch.byte_value} < SYM_LIMIT;
   assign idx      = req_ch.byte_value[IDX_W-1:0];
   assign table_wr = accept && (req_ch.cmd == CMD_TABLE_WRITE) && in_range;
   assign data_rd  = accept && (req_ch.cmd == CMD_DATA);

   // Track which table entries hold written contents.
   always_comb begin
      written_in = written_ff;
      if (table_wr) begin
         written_in[idx] = 1'b1;
      end
   end

   // Translation table and delete set: written by table writes, read by data bytes.
   always_ff @(posedge clock) begin
      if (table_wr) begin
         table_mem[idx] <= '{map_to: req_ch.map_to, del_mark: req_ch.mark_delete};
      end
      if (data_rd) begin
         a_word_ff <= table_mem[idx];
         a_byte_ff <= req_ch.byte_value;
         a_hit_ff  <= in_range && written_ff[idx];
      end
   end

   // Translated byte and delete mark out of the lookup stage.
   assign a_mapped      = a_hit_ff ? a_word_ff.map_to : a_byte_ff;
   assign a_del         = a_hit_ff && a_word_ff.del_mark;
   assign a_sq_in_range = {1'b0, a_mapped} < SYM_LIMIT;
   assign a_sq_idx      = a_mapped[IDX_W-1:0];

   // Squeeze set: indexed by the translated byte one stage later.
   always_ff @(posedge clock) begin
      if (table_wr) begin
         sq_mem[idx] <= req_ch.mark_squeeze;
      end
      if (a_valid_ff) begin
         b_sq_word_ff <= sq_mem[a_sq_idx];
         b_sq_hit_ff  <= a_sq_in_range && written_ff[a_sq_idx];
         b_mapped_ff  <= a_mapped;
         b_del_ff     <= a_del;
      end
   end

   // Stage valid bits and entry tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         a_valid_ff <= data_rd;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Deleted bytes stop here; the rest go into the queue.
   assign push = b_valid_ff && !(cfg.delete_enable && b_del_ff);
   assign push_entry.mapped       = b_mapped_ff;
   assign push_entry.squeeze_mark = b_sq_hit_ff && b_sq_word_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bts_queue.sv =====
// Small FIFO that decouples the lookup front from the emitting back.
// Depends on bts_pkg.
`default_nettype none

module bts_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bts_pkg::queue_entry_type  push_entry,
   input  wire logic                      pop,
   output bts_pkg::queue_status_type      status,
   output bts_pkg::queue_entry_type       head
);
   import bts_pkg::*;

   queue_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.count     = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bts_back.sv =====
// Back of the core: squeezes repeats against the last emitted byte and holds
// the response register. Depends on bts_pkg, bts_if.
`default_nettype none

module bts_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bts_pkg::cfg_type          cfg,
   input  wire bts_pkg::queue_status_type queue_status,
   input  wire bts_pkg::queue_entry_type  head,
   output logic                           pop,
   bts_rsp_if.source                      rsp_ch
);
   import bts_pkg::*;

   byte_type last_ff,       last_in;
   logic     last_valid_ff, last_valid_in;
   logic     out_valid_ff,  out_valid_in;
   byte_type out_byte_ff,   out_byte_in;

   logic drop;
   logic load;

   // A repeat of the last emitted byte that is marked for squeezing is dropped.
   assign drop = cfg.squeeze_enable && last_valid_ff && (last_ff == head.mapped)
                 && head.squeeze_mark;

   // Take the queue head when it is dropped or the response register is free.
   assign pop  = queue_status.not_empty && (drop || !out_valid_ff || rsp_ch.ready);
   assign load = pop && !drop;

   always_comb begin
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      out_byte_in   = out_byte_ff;
      out_valid_in  = out_valid_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         last_in       = head.mapped;
         last_valid_in = 1'b1;
         out_byte_in   = head.mapped;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         last_ff       <= last_in;
         last_valid_ff <= last_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_translate_delete_squeeze_core.sv =====
// Top level of the byte translate / delete / squeeze core: control registers
// and the front, queue and back. Depends on bts_pkg, bts_if, bts_front,
// bts_queue and bts_back.
//
//   Channel  Direction  Carries
//   req_ch   in         cmd, byte_value, map_to, mark_delete, mark_squeeze
//   rsp_ch   out        out_byte
//   csr_ch   in         index, data (bit 0 sets the mode)
//
// One request is taken per clock while req_ch.ready is high; a data byte that
// survives passes through the lookup stage, the squeeze lookup stage, the
// queue slot and the response register on its way to rsp_ch. Table writes
// take effect for the next request. No clearing pass is needed at reset:
// valid bits per table entry make the table read as identity with both sets clear.
// A stalled response fills the four-entry queue; req_ch.ready drops once the
// queue count plus the bytes in the two lookup stages reaches the queue depth.
`default_nettype none

module byte_translate_delete_squeeze_core #(
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   bts_req_if.sink   req_ch,
   bts_rsp_if.source rsp_ch,
   bts_csr_if.sink   csr_ch
);
   import bts_pkg::*;

   logic delete_enable_ff,  delete_enable_in;
   logic squeeze_enable_ff, squeeze_enable_in;

   cfg_type          cfg;
   queue_status_type queue_status;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   logic             push;
   logic             pop;

   // Control registers are always ready for a transfer.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      delete_enable_in  = delete_enable_ff;
      squeeze_enable_in = squeeze_enable_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DELETE_ENABLE:  delete_enable_in  = csr_ch.data[0];
            CSR_SQUEEZE_ENABLE: squeeze_enable_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delete_enable_ff  <= 1'b0;
         squeeze_enable_ff <= 1'b0;
      end else begin
         delete_enable_ff  <= delete_enable_in;
         squeeze_enable_ff <= squeeze_enable_in;
      end
   end

   assign cfg.delete_enable  = delete_enable_ff;
   assign cfg.squeeze_enable = squeeze_enable_ff;

   bts_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .cfg          (cfg),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (queue_status),
      .head       (head)
   );

   bts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .rsp_ch       (rsp_ch)
   );

endmodule

`default_nettype wire
